FILE: src/rlrg_pkg.sv
// Shared types, codes and hue helpers of the rainbow LED ring generator.
package rlrg_pkg;

  localparam int unsigned IDX_W     = 6;
  localparam int unsigned CFG_W     = 10;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned MS_W      = 10;

  localparam logic [MS_W-1:0] ELAPSED_MAX = 10'd1023;

  localparam logic [2:0] OP_TICK      = 3'd0;
  localparam logic [2:0] OP_SET_ALL   = 3'd1;
  localparam logic [2:0] OP_SET_PIXEL = 3'd2;
  localparam logic [2:0] OP_CLEAR     = 3'd3;
  localparam logic [2:0] OP_RAINBOW   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SATURATION = 2'd2;

  localparam logic [MS_W-1:0] INTERVAL_RST   = 10'd60;
  localparam logic [7:0]      BRIGHTNESS_RST = 8'd100;
  localparam logic [7:0]      SATURATION_RST = 8'd255;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SF,
    ST_SNF,
    ST_P,
    ST_Q,
    ST_T,
    ST_PUSH
  } state_e;

  typedef enum logic [2:0] {
    SEC_0,
    SEC_1,
    SEC_2,
    SEC_3,
    SEC_4,
    SEC_5
  } sector_e;

  function automatic sector_e hue_sector(input logic [7:0] h);
    sector_e s;
    priority if (h < 8'd43)  s = SEC_0;
    else if (h < 8'd86)      s = SEC_1;
    else if (h < 8'd129)     s = SEC_2;
    else if (h < 8'd172)     s = SEC_3;
    else if (h < 8'd215)     s = SEC_4;
    else                     s = SEC_5;
    return s;
  endfunction

  function automatic logic [7:0] sector_base(input sector_e s);
    logic [7:0] b;
    unique case (s)
      SEC_0:   b = 8'd0;
      SEC_1:   b = 8'd43;
      SEC_2:   b = 8'd86;
      SEC_3:   b = 8'd129;
      SEC_4:   b = 8'd172;
      SEC_5:   b = 8'd215;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] hue_frac(input logic [7:0] h);
    logic [7:0] d;
    d = h - sector_base(hue_sector(h));
    return 8'(10'(d) * 10'd6);
  endfunction

endpackage

FILE: src/rlrg_if.sv
// Valid/ready channel interfaces for commands and LED writes.
interface rlrg_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [7:0] pixel_index;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic       enable;

  modport source (output valid, op, pixel_index, red_in, green_in, blue_in, enable,
                  input ready);
  modport sink   (input valid, op, pixel_index, red_in, green_in, blue_in, enable,
                  output ready);
endinterface

interface rlrg_pix_if;
  logic       valid;
  logic       ready;
  logic [5:0] led_index;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       last_of_frame;
  logic       animating;

  modport source (output valid, led_index, red_out, green_out, blue_out, last_of_frame,
                  animating, input ready);
  modport sink   (input valid, led_index, red_out, green_out, blue_out, last_of_frame,
                  animating, output ready);
endinterface

FILE: src/rainbow_led_ring_generator.sv
// Rainbow LED ring generator: command decode, frame timing and iterative HSV-to-RGB.
//
//  channel   dir   payload                                              handshake
//  cmd_i     in    op, pixel_index, red_in, green_in, blue_in, enable   valid/ready
//  pix_o     out   led_index, red/green/blue_out, last_of_frame, anim   valid/ready
//  cfg       in    cfg_idx_i, cfg_data_i                                cfg_we_i
//
// For a rainbow frame each LED takes 5 passes through the one shared 8x8 multiplier
// (states SF, SNF, P, Q, T), then the write in the push state.
// Set all and clear write every LED in turn; set pixel writes one LED; other items stay idle.
// cmd_i.ready is high only while the sequencer is idle; pix_o stalls hold the sequencer.
// rst_ni resets mode, timing and register state to their defaults at once; no clearing pass.
module rainbow_led_ring_generator
  import rlrg_pkg::*;
#(
  parameter int unsigned LED_COUNT = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  rlrg_cmd_if.sink             cmd_i,
  rlrg_pix_if.source           pix_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam logic [7:0]       HUE_STEP = 8'(256 / LED_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LED_COUNT - 1);
  localparam logic [7:0]       COUNT_B  = 8'(LED_COUNT);

  state_e           state_q, state_d;
  logic             rainbow_q;
  logic             due_q;
  logic [7:0]       hue_q;
  logic [MS_W-1:0]  elapsed_q;
  logic [MS_W-1:0]  interval_q;
  logic [7:0]       bright_q;
  logic [7:0]       sat_q;

  logic [7:0]       cur_hue_q;
  logic [IDX_W-1:0] idx_q;
  logic             frame_q;
  logic             single_q;
  logic [7:0]       r_q, g_q, b_q;
  logic [7:0]       sa_q, sb_q, p_q, q_q, t_q;

  logic             out_valid_q;
  logic [IDX_W-1:0] out_idx_q;
  logic [7:0]       out_r_q, out_g_q, out_b_q;
  logic             out_last_q;
  logic             out_anim_q;

  logic             accept;
  logic             in_range;
  logic [MS_W-1:0]  elapsed_inc;
  logic             start_frame;
  logic             start_fill;
  logic             start_one;
  logic             is_last;
  logic             out_free;
  logic             push_fire;
  sector_e          sector;
  logic [7:0]       frac;
  logic [7:0]       mul_a, mul_b;
  logic [15:0]      prod;
  logic [7:0]       pix_r, pix_g, pix_b;

  assign cmd_i.ready = (state_q == ST_IDLE);
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign in_range    = cmd_i.pixel_index < COUNT_B;
  assign elapsed_inc = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + 1'b1;
  assign start_frame = (cmd_i.op == OP_TICK) && rainbow_q &&
                       (due_q || (elapsed_inc >= interval_q));
  assign start_fill  = (cmd_i.op == OP_SET_ALL) || (cmd_i.op == OP_CLEAR);
  assign start_one   = (cmd_i.op == OP_SET_PIXEL) && in_range;
  assign is_last     = single_q || (idx_q == LAST_IDX);
  assign out_free    = !out_valid_q || pix_o.ready;
  assign push_fire   = (state_q == ST_PUSH) && out_free;

  assign sector = hue_sector(cur_hue_q);
  assign frac   = hue_frac(cur_hue_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (start_frame)) begin
          state_d = ST_SF;
        end else if (accept && (start_fill || start_one)) begin
          state_d = ST_PUSH;
        end
      end
      ST_SF:   state_d = ST_SNF;
      ST_SNF:  state_d = ST_P;
      ST_P:    state_d = ST_Q;
      ST_Q:    state_d = ST_T;
      ST_T:    state_d = ST_PUSH;
      ST_PUSH: begin
        if (out_free) begin
          if (is_last) begin
            state_d = ST_IDLE;
          end else if (frame_q) begin
            state_d = ST_SF;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    mul_a = bright_q;
    mul_b = 8'd0;
    unique case (state_q)
      ST_SF: begin
        mul_a = sat_q;
        mul_b = frac;
      end
      ST_SNF: begin
        mul_a = sat_q;
        mul_b = 8'd255 - frac;
      end
      ST_P:    mul_b = 8'd255 - sat_q;
      ST_Q:    mul_b = 8'd255 - sa_q;
      ST_T:    mul_b = 8'd255 - sb_q;
      default: mul_b = 8'd0;
    endcase
  end

  assign prod = 16'(mul_a) * 16'(mul_b);

  always_comb begin
    pix_r = r_q;
    pix_g = g_q;
    pix_b = b_q;
    if (frame_q) begin
      if (sat_q == 8'd0) begin
        pix_r = bright_q;
        pix_g = bright_q;
        pix_b = bright_q;
      end else begin
        unique case (sector)
          SEC_0: begin pix_r = bright_q; pix_g = t_q;      pix_b = p_q;      end
          SEC_1: begin pix_r = q_q;      pix_g = bright_q; pix_b = p_q;      end
          SEC_2: begin pix_r = p_q;      pix_g = bright_q; pix_b = t_q;      end
          SEC_3: begin pix_r = p_q;      pix_g = q_q;      pix_b = bright_q; end
          SEC_4: begin pix_r = t_q;      pix_g = p_q;      pix_b = bright_q; end
          default: begin pix_r = bright_q; pix_g = p_q;    pix_b = q_q;      end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rainbow_q   <= 1'b1;
      due_q       <= 1'b1;
      hue_q       <= 8'd0;
      elapsed_q   <= '0;
      interval_q  <= INTERVAL_RST;
      bright_q    <= BRIGHTNESS_RST;
      sat_q       <= SATURATION_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_INTERVAL:   interval_q <= cfg_data_i;
          REG_BRIGHTNESS: bright_q   <= cfg_data_i[7:0];
          REG_SATURATION: sat_q      <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (accept) begin
        unique case (cmd_i.op)
          OP_TICK: begin
            if (rainbow_q) begin
              if (start_frame) begin
                elapsed_q <= '0;
                due_q     <= 1'b0;
                hue_q     <= hue_q + 8'd1;
              end else begin
                elapsed_q <= elapsed_inc;
              end
            end
          end
          OP_SET_ALL, OP_CLEAR: rainbow_q <= 1'b0;
          OP_SET_PIXEL: begin
            if (in_range) begin
              rainbow_q <= 1'b0;
            end
          end
          OP_RAINBOW: begin
            rainbow_q <= cmd_i.enable;
            if (cmd_i.enable) begin
              due_q <= 1'b1;
            end
          end
          default: ;
        endcase
      end
      if (push_fire) begin
        out_valid_q <= 1'b1;
      end else if (pix_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_hue_q <= hue_q;
      idx_q     <= start_one ? cmd_i.pixel_index[IDX_W-1:0] : '0;
      frame_q   <= start_frame;
      single_q  <= start_one;
      r_q       <= (cmd_i.op == OP_CLEAR) ? 8'd0 : cmd_i.red_in;
      g_q       <= (cmd_i.op == OP_CLEAR) ? 8'd0 : cmd_i.green_in;
      b_q       <= (cmd_i.op == OP_CLEAR) ? 8'd0 : cmd_i.blue_in;
    end
    unique case (state_q)
      ST_SF:   sa_q <= prod[15:8];
      ST_SNF:  sb_q <= prod[15:8];
      ST_P:    p_q  <= prod[15:8];
      ST_Q:    q_q  <= prod[15:8];
      ST_T:    t_q  <= prod[15:8];
      default: ;
    endcase
    if (push_fire) begin
      out_idx_q  <= idx_q;
      out_r_q    <= pix_r;
      out_g_q    <= pix_g;
      out_b_q    <= pix_b;
      out_last_q <= is_last;
      out_anim_q <= rainbow_q;
      idx_q      <= idx_q + 1'b1;
      cur_hue_q  <= cur_hue_q + HUE_STEP;
    end
  end

  assign pix_o.valid         = out_valid_q;
  assign pix_o.led_index     = out_idx_q;
  assign pix_o.red_out       = out_r_q;
  assign pix_o.green_out     = out_g_q;
  assign pix_o.blue_out      = out_b_q;
  assign pix_o.last_of_frame = out_last_q;
  assign pix_o.animating     = out_anim_q;

endmodule

FILE: src/rlrg_check.sv
// Port-level assertions for the rainbow LED ring generator, bound to the top level.
module rlrg_check
  import rlrg_pkg::*;
#(
  parameter int unsigned LED_COUNT = 16
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic [2:0]       in_op_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [IDX_W-1:0] led_index_i,
  input logic [7:0]       red_i,
  input logic [7:0]       green_i,
  input logic [7:0]       blue_i,
  input logic             last_i,
  input logic             anim_i
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LED_COUNT - 1);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(led_index_i) &&
      $stable(red_i) && $stable(green_i) && $stable(blue_i) && $stable(last_i))
    else $error("stalled LED write changed");

  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && anim_i && last_i |-> led_index_i == LAST_IDX)
    else $error("rainbow frame ended before the last LED");

  a_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !last_i |-> led_index_i != LAST_IDX)
    else $error("last LED written without refresh mark");

  a_fill_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_op_i == OP_SET_ALL || in_op_i == OP_CLEAR)
      |=> !in_ready_i)
    else $error("fill run accepted a new command at once");

endmodule

bind rainbow_led_ring_generator rlrg_check #(.LED_COUNT(LED_COUNT)) u_rlrg_check (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (cmd_i.valid),
  .in_ready_i  (cmd_i.ready),
  .in_op_i     (cmd_i.op),
  .out_valid_i (pix_o.valid),
  .out_ready_i (pix_o.ready),
  .led_index_i (pix_o.led_index),
  .red_i       (pix_o.red_out),
  .green_i     (pix_o.green_out),
  .blue_i      (pix_o.blue_out),
  .last_i      (pix_o.last_of_frame),
  .anim_i      (pix_o.animating)
);
